// ----- hdl/phc_pkg.sv -----
package phc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_CAL_TEMPERATURE     = 3'd0;
  localparam logic [2:0] CFG_CAL_PRESSURE_FIRST  = 3'd1;
  localparam logic [2:0] CFG_CAL_PRESSURE_SECOND = 3'd2;
  localparam logic [2:0] CFG_CAL_MIXED           = 3'd3;
  localparam logic [2:0] CFG_CAL_HUMIDITY_SHAPE  = 3'd4;
  localparam logic [2:0] CFG_HUMIDITY_ENABLE     = 3'd5;

  // Quotient bits resolved by the divider, one per stage
  localparam int DIV_STEPS = 64;

  // Compensation constants
  localparam logic signed [33:0] T_FINE_OFS = 34'sd128000;
  localparam logic [63:0]        PRES_SCALE = 64'd3125;
  localparam logic [63:0]        PRES_BASE  = 64'd1048576;
  localparam logic signed [31:0] HUM_OFS    = 32'sd76800;
  localparam logic signed [31:0] HUM_MAX    = 32'sd419430400;
  localparam logic signed [31:0] HUM_ROUND  = 32'sd16384;
  localparam logic signed [31:0] HUM_BIAS   = 32'sd2097152;
  localparam logic signed [31:0] HUM_HALF   = 32'sd8192;
  localparam logic signed [31:0] HUM_ONE    = 32'sd32768;
  localparam logic signed [31:0] TEMP_MIN   = -32'sd262144;
  localparam logic signed [31:0] TEMP_MAX   = 32'sd262143;

  // Results that ride alongside the pressure division
  typedef struct packed {
    logic               nonzero;
    logic signed [18:0] temp;
    logic [16:0]        hum;
  } phc_side_t;

endpackage

// ----- hdl/phc_div.sv -----
module phc_div import phc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  input  phc_side_t          side_in,
  output logic               out_valid,
  output logic signed [63:0] quo,
  output phc_side_t          side_out
);

  logic [63:0] rem  [0:DIV_STEPS];
  logic [63:0] qn   [0:DIV_STEPS];
  logic [63:0] md   [0:DIV_STEPS];
  logic        neg  [0:DIV_STEPS];
  phc_side_t   side [0:DIV_STEPS];
  logic        vld  [0:DIV_STEPS];

  // Take magnitudes, remember the quotient sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    qn[0]   <= num[63] ? 64'(64'd0 - 64'(num)) : 64'(num);
    md[0]   <= den[63] ? 64'(64'd0 - 64'(den)) : 64'(den);
    neg[0]  <= num[63] ^ den[63];
    rem[0]  <= '0;
    side[0] <= side_in;
  end

  // One restoring step per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [64:0] shifted;
    logic [65:0] trial;
    assign shifted = {rem[k], qn[k][63]};
    assign trial   = {1'b0, shifted} - {2'b00, md[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      if (!trial[65]) begin
        rem[k+1] <= trial[63:0];
        qn[k+1]  <= {qn[k][62:0], 1'b1};
      end else begin
        rem[k+1] <= shifted[63:0];
        qn[k+1]  <= {qn[k][62:0], 1'b0};
      end
      md[k+1]   <= md[k];
      neg[k+1]  <= neg[k];
      side[k+1] <= side[k];
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[DIV_STEPS];
    end
    quo      <= neg[DIV_STEPS] ? $signed(64'd0 - qn[DIV_STEPS]) : $signed(qn[DIV_STEPS]);
    side_out <= side[DIV_STEPS];
  end

endmodule

// ----- hdl/pressure_humidity_compensation.sv -----
// Channel     Handshake                 Payload
// input       start / busy              raw_pressure, raw_temperature, raw_humidity
// result      done (one-cycle strobe)   temperature_centi, pressure_q24_8,
//                                       pressure_valid, humidity_q22_10
// config      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transfer per cycle is taken outside reset; the pipeline never stops.
// Each result passes through 13 front stages (fine temperature, humidity and
// the pressure operands), the one-bit-per-stage 64-bit divider, and 5 back
// stages for the pressure tail. busy is high only during reset, and
// synchronous reset flushes all valid bits and clears the calibration
// registers. The receiver cannot stall, so results move out on done without
// any holding logic.
module pressure_humidity_compensation import phc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_pressure,
  input  logic [19:0]        raw_temperature,
  input  logic [15:0]        raw_humidity,
  output logic               done,
  output logic signed [18:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_valid,
  output logic [16:0]        humidity_q22_10,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // ------------------------------------------------------------------
  // Calibration registers
  // ------------------------------------------------------------------
  logic [47:0] cal_temperature;
  logic [63:0] cal_pressure_first;
  logic [63:0] cal_pressure_second;
  logic [47:0] cal_mixed;
  logic [39:0] cal_humidity_shape;
  logic        humidity_enable;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temperature     <= '0;
      cal_pressure_first  <= '0;
      cal_pressure_second <= '0;
      cal_mixed           <= '0;
      cal_humidity_shape  <= '0;
      humidity_enable     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAL_TEMPERATURE:     cal_temperature     <= cfg_data[47:0];
        CFG_CAL_PRESSURE_FIRST:  cal_pressure_first  <= cfg_data;
        CFG_CAL_PRESSURE_SECOND: cal_pressure_second <= cfg_data;
        CFG_CAL_MIXED:           cal_mixed           <= cfg_data[47:0];
        CFG_CAL_HUMIDITY_SHAPE:  cal_humidity_shape  <= cfg_data[39:0];
        CFG_HUMIDITY_ENABLE:     humidity_enable     <= cfg_data[0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Unpack the calibration words
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]         h1, h3;
  logic signed [7:0]  h6;

  assign t1 = cal_temperature[15:0];
  assign t2 = $signed(cal_temperature[31:16]);
  assign t3 = $signed(cal_temperature[47:32]);
  assign p1 = cal_pressure_first[15:0];
  assign p2 = $signed(cal_pressure_first[31:16]);
  assign p3 = $signed(cal_pressure_first[47:32]);
  assign p4 = $signed(cal_pressure_first[63:48]);
  assign p5 = $signed(cal_pressure_second[15:0]);
  assign p6 = $signed(cal_pressure_second[31:16]);
  assign p7 = $signed(cal_pressure_second[47:32]);
  assign p8 = $signed(cal_pressure_second[63:48]);
  assign p9 = $signed(cal_mixed[15:0]);
  assign h1 = cal_mixed[23:16];
  assign h2 = $signed(cal_mixed[39:24]);
  assign h3 = cal_mixed[47:40];
  assign h4 = $signed(cal_humidity_shape[15:0]);
  assign h5 = $signed(cal_humidity_shape[31:16]);
  assign h6 = $signed(cal_humidity_shape[39:32]);

  // ------------------------------------------------------------------
  // Front pipeline valid bits and carried fields
  // ------------------------------------------------------------------
  logic [12:0]        vld;
  logic [19:0]        adc_p_pipe [0:10];
  logic [15:0]        adc_h_pipe [0:5];
  logic signed [18:0] tc_pipe    [4:12];
  logic signed [33:0] x1_pipe    [4:7];
  logic [19:0]        s0_adc_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[11:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    adc_p_pipe[0] <= raw_pressure;
    adc_h_pipe[0] <= raw_humidity;
    s0_adc_t      <= raw_temperature;
    for (int i = 1; i <= 10; i++) adc_p_pipe[i] <= adc_p_pipe[i-1];
    for (int i = 1; i <= 5; i++)  adc_h_pipe[i] <= adc_h_pipe[i-1];
    for (int i = 5; i <= 12; i++) tc_pipe[i]    <= tc_pipe[i-1];
    for (int i = 5; i <= 7; i++)  x1_pipe[i]    <= x1_pipe[i-1];
  end

  // ------------------------------------------------------------------
  // Fine temperature, stages 1 to 4
  // ------------------------------------------------------------------
  logic signed [18:0] ta;
  logic signed [17:0] td;
  logic signed [34:0] pa_full;
  logic signed [35:0] dd_full;
  logic signed [47:0] m_full;
  logic signed [31:0] s1_pa, s1_dd, s2_v1, s2_m, s3_tf;
  logic signed [31:0] t5, tcs;
  logic signed [31:0] s4_vh;

  always_comb begin
    ta      = $signed({2'b00, s0_adc_t[19:3]}) - $signed({2'b00, t1, 1'b0});
    td      = $signed({2'b00, s0_adc_t[19:4]}) - $signed({2'b00, t1});
    pa_full = ta * t2;
    dd_full = td * td;
    m_full  = (s1_dd >>> 12) * t3;
    t5      = (s3_tf <<< 2) + s3_tf + 32'sd128;
    tcs     = t5 >>> 8;
  end

  always_ff @(posedge clk) begin
    s1_pa <= pa_full[31:0];
    s1_dd <= dd_full[31:0];
    s2_v1 <= s1_pa >>> 11;
    s2_m  <= m_full[31:0];
    s3_tf <= s2_v1 + (s2_m >>> 14);
    // clamp the centi-degree value to its 19-bit range
    if (tcs < TEMP_MIN) begin
      tc_pipe[4] <= TEMP_MIN[18:0];
    end else if (tcs > TEMP_MAX) begin
      tc_pipe[4] <= TEMP_MAX[18:0];
    end else begin
      tc_pipe[4] <= tcs[18:0];
    end
    x1_pipe[4] <= $signed({{2{s3_tf[31]}}, s3_tf}) - T_FINE_OFS;
    s4_vh      <= s3_tf - HUM_OFS;
  end

  // ------------------------------------------------------------------
  // Humidity, stages 5 to 12 (32-bit wrap)
  // ------------------------------------------------------------------
  logic signed [47:0] m5_full;
  logic signed [39:0] m6_full;
  logic signed [40:0] m3_full;
  logic signed [31:0] s5_m5, s5_m6, s5_m3;
  logic signed [31:0] ha_sum;
  logic signed [31:0] s6_ha, s6_hb, s6_hc;
  logic signed [63:0] mbc_full;
  logic signed [31:0] s7_mbc, s7_ha;
  logic signed [31:0] hd;
  logic signed [47:0] mh_full;
  logic signed [31:0] s8_mh, s8_ha;
  logic signed [31:0] he;
  logic signed [63:0] vv_full;
  logic signed [31:0] s9_vv;
  logic signed [31:0] hq;
  logic signed [63:0] qq_full;
  logic signed [31:0] s10_qq, s10_vv;
  logic signed [40:0] mq_full;
  logic signed [31:0] s11_mq, s11_vv;
  logic signed [31:0] hr;
  logic [16:0]        s12_hum;

  always_comb begin
    m5_full  = h5 * s4_vh;
    m6_full  = s4_vh * h6;
    m3_full  = s4_vh * $signed({1'b0, h3});
    ha_sum   = $signed({2'b00, adc_h_pipe[5], 14'd0}) - $signed({h4[11:0], 20'd0})
               - s5_m5 + HUM_ROUND;
    mbc_full = s6_hb * s6_hc;
    hd       = (s7_mbc >>> 10) + HUM_BIAS;
    mh_full  = hd * h2;
    he       = (s8_mh + HUM_HALF) >>> 14;
    vv_full  = s8_ha * he;
    hq       = s9_vv >>> 15;
    qq_full  = hq * hq;
    mq_full  = (s10_qq >>> 7) * $signed({1'b0, h1});
    hr       = s11_vv - (s11_mq >>> 4);
  end

  always_ff @(posedge clk) begin
    s5_m5  <= m5_full[31:0];
    s5_m6  <= m6_full[31:0];
    s5_m3  <= m3_full[31:0];
    s6_ha  <= ha_sum >>> 15;
    s6_hb  <= s5_m6 >>> 10;
    s6_hc  <= (s5_m3 >>> 11) + HUM_ONE;
    s7_mbc <= mbc_full[31:0];
    s7_ha  <= s6_ha;
    s8_mh  <= mh_full[31:0];
    s8_ha  <= s7_ha;
    s9_vv  <= vv_full[31:0];
    s10_qq <= qq_full[31:0];
    s10_vv <= s9_vv;
    s11_mq <= mq_full[31:0];
    s11_vv <= s10_vv;
    // clamp to 0..100 %RH, then drop 12 fraction bits
    if (!humidity_enable || hr[31]) begin
      s12_hum <= '0;
    end else if (hr > HUM_MAX) begin
      s12_hum <= HUM_MAX[28:12];
    end else begin
      s12_hum <= hr[28:12];
    end
  end

  // ------------------------------------------------------------------
  // Pressure operands, stages 8 to 12 (64-bit wrap)
  // ------------------------------------------------------------------
  logic signed [67:0] sq_full;
  logic signed [49:0] x1p5_full, x1p2_full;
  logic signed [63:0] s8_sq;
  logic signed [49:0] s8_x1p5, s8_x1p2;
  logic signed [79:0] t6_full, t3_full;
  logic signed [63:0] s9_t6, s9_t3;
  logic signed [49:0] s9_x1p5, s9_x1p2;
  logic signed [63:0] s10_x2, s10_x1b;
  logic signed [63:0] x1s;
  logic signed [80:0] prod_full;
  logic [63:0]        pp;
  logic [63:0]        s11_prod, s11_diff;
  logic signed [63:0] s12_num, s12_dvs;
  logic               s12_nz;

  always_comb begin
    sq_full   = x1_pipe[7] * x1_pipe[7];
    x1p5_full = x1_pipe[7] * p5;
    x1p2_full = x1_pipe[7] * p2;
    t6_full   = s8_sq * p6;
    t3_full   = s8_sq * p3;
    x1s       = s10_x1b + $signed(64'h0000_8000_0000_0000);
    prod_full = x1s * $signed({1'b0, p1});
    pp        = PRES_BASE - {44'd0, adc_p_pipe[10]};
  end

  always_ff @(posedge clk) begin
    s8_sq    <= sq_full[63:0];
    s8_x1p5  <= x1p5_full;
    s8_x1p2  <= x1p2_full;
    s9_t6    <= t6_full[63:0];
    s9_t3    <= t3_full[63:0];
    s9_x1p5  <= s8_x1p5;
    s9_x1p2  <= s8_x1p2;
    s10_x2   <= s9_t6 + (64'(s9_x1p5) <<< 17) + (64'(p4) <<< 35);
    s10_x1b  <= (s9_t3 >>> 8) + (64'(s9_x1p2) <<< 12);
    s11_prod <= prod_full[63:0];
    s11_diff <= (pp << 31) - 64'(s10_x2);
    s12_num  <= $signed(s11_diff * PRES_SCALE);
    s12_dvs  <= $signed(s11_prod) >>> 33;
    s12_nz   <= |s11_prod[63:33];
  end

  // ------------------------------------------------------------------
  // Division, with temperature and humidity riding along
  // ------------------------------------------------------------------
  phc_side_t          div_side_in, div_side;
  logic               div_valid;
  logic signed [63:0] div_q;

  assign div_side_in = '{nonzero: s12_nz, temp: tc_pipe[12], hum: s12_hum};

  phc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[12]),
    .num      (s12_num),
    .den      (s12_dvs),
    .side_in  (div_side_in),
    .out_valid(div_valid),
    .quo      (div_q),
    .side_out (div_side)
  );

  // ------------------------------------------------------------------
  // Pressure tail, 5 stages
  // ------------------------------------------------------------------
  logic [4:0]         pv;
  logic signed [63:0] ps;
  logic [63:0]        lolo_c, cross_c;
  logic signed [79:0] y2_full, y1_full;
  logic [63:0]        k1_lolo;
  logic [31:0]        k1_cross;
  logic signed [63:0] k1_y2, k1_p;
  logic [63:0]        k2_sq;
  logic signed [63:0] k2_y2, k2_p, k3_y1, k3_y2, k3_p, k4_sum;
  phc_side_t          k_side [1:4];
  logic signed [63:0] pf;

  always_comb begin
    ps      = div_q >>> 13;
    // ps*ps taken mod 2^64 from 32-bit partial products
    lolo_c  = ps[31:0] * ps[31:0];
    cross_c = ps[63:32] * ps[31:0];
    y2_full = div_q * p8;
    y1_full = $signed(k2_sq) * p9;
    pf      = (k4_sum >>> 8) + (64'(p7) <<< 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= '0;
      done <= 1'b0;
    end else begin
      pv   <= {pv[3:0], div_valid};
      done <= pv[3];
    end
    k1_lolo   <= lolo_c;
    k1_cross  <= cross_c[31:0];
    k1_y2     <= y2_full[63:0];
    k1_p      <= div_q;
    k_side[1] <= div_side;
    k2_sq     <= k1_lolo + {k1_cross[30:0], 33'd0};
    k2_y2     <= k1_y2;
    k2_p      <= k1_p;
    k_side[2] <= k_side[1];
    k3_y1     <= y1_full[63:0];
    k3_y2     <= k2_y2;
    k3_p      <= k2_p;
    k_side[3] <= k_side[2];
    k4_sum    <= k3_p + (k3_y1 >>> 25) + (k3_y2 >>> 19);
    k_side[4] <= k_side[3];
    // saturate pressure to 0..2^32-1; force zero when the divisor was zero
    if (!k_side[4].nonzero || pf[63]) begin
      pressure_q24_8 <= '0;
    end else if (|pf[62:32]) begin
      pressure_q24_8 <= '1;
    end else begin
      pressure_q24_8 <= pf[31:0];
    end
    pressure_valid    <= k_side[4].nonzero;
    temperature_centi <= k_side[4].temp;
    humidity_q22_10   <= k_side[4].hum;
  end

endmodule

// ----- hdl/phc_checker.sv -----
module phc_checker import phc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        pressure_valid,
  input logic [31:0] pressure_q24_8,
  input logic [16:0] humidity_q22_10
);

  localparam int LATENCY = 84;

  // every result traces back to a matching input transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching input transfer");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (done && !pressure_valid) |-> (pressure_q24_8 == 32'd0))
    else $error("pressure not forced to zero on zero divisor");

  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> (humidity_q22_10 <= 17'd102400))
    else $error("humidity above 100 percent");

endmodule

bind pressure_humidity_compensation phc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .pressure_valid (pressure_valid),
  .pressure_q24_8 (pressure_q24_8),
  .humidity_q22_10(humidity_q22_10)
);

// ----- test/pressure_humidity_compensation_tb.sv -----
`timescale 1ns / 1ps

module pressure_humidity_compensation_tb;
  import phc_pkg::*;

  // Compensated reading as it leaves the block
  typedef struct packed {
    logic signed [18:0] temp;
    logic [31:0]        pres;
    logic               pvalid;
    logic [16:0]        hum;
  } reading_t;

  // One directed stimulus row; lit_en marks rows whose reading is typed in
  typedef struct packed {
    logic [19:0] p;
    logic [19:0] t;
    logic [15:0] h;
    logic        lit_en;
    reading_t    lit;
  } stim_row_t;

  localparam int LATENCY    = 84;
  localparam int DRAIN      = LATENCY + 16;
  localparam int RAND_ITEMS = 640;
  localparam int RAND_PHASE = 80;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  logic [15:0] raw_humidity;
  logic        done;
  logic signed [18:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic        pressure_valid;
  logic [16:0] humidity_q22_10;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // Typed-in expectation that rides along with the item being driven
  logic        lit_en;
  reading_t    lit_reading;

  // Shadow copy of the calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_pres_a;
  logic [63:0] cal_pres_b;
  logic [47:0] cal_mix;
  logic [39:0] cal_hshape;
  logic        hum_on;

  reading_t    pending_readings[$];
  int          errors;
  int          readings_seen;
  int          items_sent;
  int          cal_sets;

  pressure_humidity_compensation u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .raw_pressure     (raw_pressure),
    .raw_temperature  (raw_temperature),
    .raw_humidity     (raw_humidity),
    .done             (done),
    .temperature_centi(temperature_centi),
    .pressure_q24_8   (pressure_q24_8),
    .pressure_valid   (pressure_valid),
    .humidity_q22_10  (humidity_q22_10),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs or the drain never completes
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [31:0] sx16_32(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx16_64(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  // Signed 64-bit quotient truncated toward zero, wrapping on overflow
  function automatic logic [63:0] quot64(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // Compensate one raw triple against the shadow calibration
  function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    reading_t    r;
    logic [31:0] adc_t, adc_h, t1, t2, t3, a, v1, d, v2, tf, tc;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, ha, hb, hc, hd, he, q;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, p, ps, y1, y2;
    adc_t = {12'd0, rt};
    adc_h = {16'd0, rh};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sx16_32(cal_temp[31:16]);
    t3 = sx16_32(cal_temp[47:32]);

    // Fine temperature, 32-bit wrap
    a  = (adc_t >> 3) - (t1 << 1);
    v1 = asr32(a * t2, 11);
    d  = (adc_t >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    tc = asr32(tf * 32'd5 + 32'd128, 8);
    if ($signed(tc) < TEMP_MIN) tc = TEMP_MIN;
    else if ($signed(tc) > TEMP_MAX) tc = TEMP_MAX;
    r.temp = tc[18:0];

    // Pressure, 64-bit wrap
    p1 = {48'd0, cal_pres_a[15:0]};
    p2 = sx16_64(cal_pres_a[31:16]);
    p3 = sx16_64(cal_pres_a[47:32]);
    p4 = sx16_64(cal_pres_a[63:48]);
    p5 = sx16_64(cal_pres_b[15:0]);
    p6 = sx16_64(cal_pres_b[31:16]);
    p7 = sx16_64(cal_pres_b[47:32]);
    p8 = sx16_64(cal_pres_b[63:48]);
    p9 = sx16_64(cal_mix[15:0]);
    x1 = {{32{tf[31]}}, tf} - 64'd128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) << 17);
    x2 = x2 + (p4 << 35);
    x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
    x1 = asr64((64'h0000_8000_0000_0000 + x1) * p1, 33);
    r.pres   = '0;
    r.pvalid = 1'b0;
    if (x1 != 64'd0) begin
      p  = 64'd1048576 - {44'd0, rp};
      p  = quot64(((p << 31) - x2) * 64'd3125, x1);
      ps = asr64(p, 13);
      y1 = asr64(p9 * ps * ps, 25);
      y2 = asr64(p8 * p, 19);
      p  = asr64(p + y1 + y2, 8) + (p7 << 4);
      if (p[63]) r.pres = '0;
      else if (p[63:32] != 32'd0) r.pres = '1;
      else r.pres = p[31:0];
      r.pvalid = 1'b1;
    end

    // Humidity, 32-bit wrap
    r.hum = '0;
    if (hum_on) begin
      h1 = {24'd0, cal_mix[23:16]};
      h2 = sx16_32(cal_mix[39:24]);
      h3 = {24'd0, cal_mix[47:40]};
      h4 = sx16_32(cal_hshape[15:0]);
      h5 = sx16_32(cal_hshape[31:16]);
      h6 = {{24{cal_hshape[39]}}, cal_hshape[39:32]};
      v  = tf - 32'd76800;
      ha = asr32((adc_h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
      hb = asr32(v * h6, 10);
      hc = asr32(v * h3, 11) + 32'd32768;
      hd = asr32(hb * hc, 10) + 32'd2097152;
      he = asr32(hd * h2 + 32'd8192, 14);
      v  = ha * he;
      q  = asr32(v, 15);
      v  = v - asr32(asr32(q * q, 7) * h1, 4);
      if (v[31]) v = 32'd0;
      else if (v > 32'd419430400) v = 32'd419430400;
      r.hum = v[28:12];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Record accepted config writes and items; check every reading on done
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAL_TEMPERATURE:     cal_temp   <= cfg_data[47:0];
          CFG_CAL_PRESSURE_FIRST:  cal_pres_a <= cfg_data;
          CFG_CAL_PRESSURE_SECOND: cal_pres_b <= cfg_data;
          CFG_CAL_MIXED:           cal_mix    <= cfg_data[47:0];
          CFG_CAL_HUMIDITY_SHAPE:  cal_hshape <= cfg_data[39:0];
          CFG_HUMIDITY_ENABLE:     hum_on     <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (lit_en) pending_readings.push_back(lit_reading);
        else pending_readings.push_back(compensate(raw_pressure, raw_temperature,
                                                   raw_humidity));
      end
      if (done) begin
        reading_t want;
        if (pending_readings.size() == 0) begin
          $error("reading arrived with none pending");
          errors++;
        end else begin
          want = pending_readings.pop_front();
          readings_seen++;
          if (temperature_centi !== want.temp) begin
            $error("temperature_centi expected %0d actual %0d", want.temp, temperature_centi);
            errors++;
          end
          if (pressure_q24_8 !== want.pres) begin
            $error("pressure_q24_8 expected %0d actual %0d", want.pres, pressure_q24_8);
            errors++;
          end
          if (pressure_valid !== want.pvalid) begin
            $error("pressure_valid expected %0d actual %0d", want.pvalid, pressure_valid);
            errors++;
          end
          if (humidity_q22_10 !== want.hum) begin
            $error("humidity_q22_10 expected %0d actual %0d", want.hum, humidity_q22_10);
            errors++;
          end
        end
      end
    end
  end

  // Hold one register write until the channel takes it; caller drops valid
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Wait out the pipeline, then load a full calibration set
  task automatic load_cal(logic [47:0] ct, logic [63:0] pa, logic [63:0] pb,
                          logic [47:0] cm, logic [39:0] hs, logic [63:0] en);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    write_reg(CFG_CAL_TEMPERATURE, {16'hDEAD, ct});
    write_reg(CFG_CAL_PRESSURE_FIRST, pa);
    write_reg(CFG_CAL_PRESSURE_SECOND, pb);
    write_reg(CFG_CAL_MIXED, {16'hBEEF, cm});
    write_reg(CFG_CAL_HUMIDITY_SHAPE, {24'hC0FFEE, hs});
    write_reg(CFG_HUMIDITY_ENABLE, en);
    // indexes past the list are dropped by the block
    write_reg(3'd6, {$urandom, $urandom});
    write_reg(3'd7, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
    cal_sets++;
  endtask

  // Drive one triple, hold until transfer, then idle for the requested gap
  task automatic send(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh,
                      logic le, reading_t lr, int gap);
    start           <= 1'b1;
    raw_pressure    <= rp;
    raw_temperature <= rt;
    raw_humidity    <= rh;
    lit_en          <= le;
    lit_reading     <= lr;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    stim_row_t rows [0:12];
    reading_t  zero_reading;
    int        phase_items;
    int        no_idle;
    int        pick;
    logic [19:0] rp, rt;
    logic [15:0] rh;

    zero_reading = '0;
    // With all calibration at zero every field of the reading is zero
    rows = '{
      '{20'h00000, 20'h00000, 16'h0000, 1'b1, '0},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, '0},
      '{20'h00000, 20'hFFFFF, 16'h0000, 1'b1, '0},
      '{20'hFFFFF, 20'h00000, 16'hFFFF, 1'b1, '0},
      '{20'h65A2C, 20'h7EED0, 16'h7530, 1'b1, '0},
      // predicted rows under nonzero calibration
      '{20'h65A2C, 20'h7EED0, 16'h7530, 1'b0, '0},
      '{20'h00000, 20'h00000, 16'h0000, 1'b0, '0},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '0},
      '{20'h00000, 20'hFFFFF, 16'hFFFF, 1'b0, '0},
      '{20'hFFFFF, 20'h00000, 16'h0000, 1'b0, '0},
      '{20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0, '0},
      '{20'h55555, 20'hAAAAA, 16'h5555, 1'b0, '0},
      '{20'h80000, 20'h80000, 16'h8000, 1'b0, '0}
    };

    errors = 0; readings_seen = 0; items_sent = 0; cal_sets = 0;
    cal_temp = '0; cal_pres_a = '0; cal_pres_b = '0;
    cal_mix = '0; cal_hshape = '0; hum_on = 1'b0;
    rst = 1'b1; start = 1'b0; lit_en = 1'b0; lit_reading = '0;
    raw_pressure = '0; raw_temperature = '0; raw_humidity = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: pressure divisor is zero, humidity is off
    for (int i = 0; i < 5; i++)
      send(rows[i].p, rows[i].t, rows[i].h, rows[i].lit_en, rows[i].lit, pick_gap());
    start <= 1'b0;
    lit_en <= 1'b0;

    // Typical factory calibration with humidity on
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
             {8'd0, 16'd362, 8'd75, 16'd6000},
             {8'd30, 16'd50, 16'd313}, 64'd1);
    for (int i = 5; i < 13; i++)
      send(rows[i].p, rows[i].t, rows[i].h, 1'b0, zero_reading, pick_gap());
    start <= 1'b0;

    // Every calibration word at its top value
    load_cal('1, '1, '1, '1, '1, '1);
    for (int i = 5; i < 13; i++)
      send(rows[i].p, rows[i].t, rows[i].h, 1'b0, zero_reading, 0);
    start <= 1'b0;

    // Random phases: each loads a fresh calibration set then streams items
    for (int done_items = 0; done_items < RAND_ITEMS; done_items += phase_items) begin
      pick = $urandom_range(0, 3);
      if (pick == 0)
        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 48'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                 {$urandom, $urandom});
      else if (pick == 1)
        load_cal('0, {$urandom, $urandom}, '0, '0, '0, {$urandom, $urandom});
      else
        // near-typical calibration, perturbed in the low bits of some words, with random 8-bit fields
        load_cal({16'hFC18 ^ 16'($urandom_range(0, 255)),
                  16'd26435 ^ 16'($urandom_range(0, 255)),
                  16'd27504 ^ 16'($urandom_range(0, 255))},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477 ^ 16'($urandom_range(0, 4095))},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140 ^ 16'($urandom_range(0, 63))},
                 {8'($urandom), 16'd362 ^ 16'($urandom_range(0, 255)),
                  8'($urandom), 16'd6000},
                 {8'($urandom), 16'($urandom_range(0, 200)), 16'($urandom_range(0, 600))},
                 {$urandom, $urandom});
      phase_items = RAND_PHASE;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_items; k++) begin
        rp = 20'($urandom); rt = 20'($urandom); rh = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          rp = $urandom_range(0, 1) ? '1 : '0;
          rt = $urandom_range(0, 1) ? '1 : '0;
        end else if (pick >= 2) begin
          // realistic readings keep the pressure path in its working range
          rp = 20'($urandom_range(250000, 500000));
          rt = 20'($urandom_range(400000, 620000));
        end
        send(rp, rt, rh, 1'b0, zero_reading, no_idle ? 0 : pick_gap());
      end
      start <= 1'b0;
    end

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      errors++;
    end

    $display("Sent %0d raw triples over %0d calibration sets, checked %0d readings.",
             items_sent, cal_sets, readings_seen);
    $display("Covered zero divisor, top-value and random calibration, humidity on and off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/phc_pkg.sv
hdl/phc_div.sv
hdl/pressure_humidity_compensation.sv
hdl/phc_checker.sv
test/pressure_humidity_compensation_tb.sv
